/* src/qeht_pkg.sv */
// Package: shared types and constants for the qualified extreme history tracker.
package qeht_pkg;

    localparam int NCHAN       = 9;
    localparam int CH_W        = 4;
    localparam int REC_W       = 16;
    localparam int CNT_W       = 4;
    localparam int LIMIT_W     = 4;
    localparam int S_TDATA_W   = 136;
    localparam int M_TDATA_W   = 24;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd10;
    localparam logic [CNT_W-1:0]   CNT_MAX     = 4'd15;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_LOAD   = 1'b1;

    localparam logic [CH_W-1:0] CH_CELL_MIN  = 4'd0;
    localparam logic [CH_W-1:0] CH_CELL_MAX  = 4'd1;
    localparam logic [CH_W-1:0] CH_TEMP_MIN  = 4'd2;
    localparam logic [CH_W-1:0] CH_TEMP_MAX  = 4'd3;
    localparam logic [CH_W-1:0] CH_DCHG_PEAK = 4'd4;
    localparam logic [CH_W-1:0] CH_CHG_PEAK  = 4'd5;
    localparam logic [CH_W-1:0] CH_CAPACITY  = 4'd6;
    localparam logic [CH_W-1:0] CH_BOARD_TMP = 4'd7;
    localparam logic [CH_W-1:0] CH_FLAGS     = 4'd8;

    typedef struct packed {
        logic [3:0]       pad;
        logic [15:0]      error_flags;
        logic [15:0]      board_temp_high;
        logic [15:0]      full_capacity;
        logic [15:0]      pack_current;
        logic [7:0]       pack_temp_high;
        logic [7:0]       pack_temp_low;
        logic [15:0]      cell_max_mv;
        logic [15:0]      cell_min_mv;
        logic [15:0]      load_value;
        logic [CH_W-1:0]  load_channel;
    } in_beat_t;

    typedef struct packed {
        logic [3:0]       pad;
        logic [REC_W-1:0] value;
        logic [CH_W-1:0]  channel;
    } out_beat_t;

    typedef struct packed {
        logic [NCHAN-1:0]            mask;
        logic [NCHAN-1:0][REC_W-1:0] value;
    } write_set_t;

endpackage

/* src/qualified_extreme_history_tracker.sv */
// Top level: qualified extreme history tracker over nine record channels.
//
//  channel | direction | signals                      | beat contents (low bit up)
//  --------+-----------+------------------------------+-------------------------------------
//  s_      | in        | s_tvalid s_tready s_tdata    | item: sample set or record preset
//          |           | s_tuser                      | func
//  m_      | out       | m_tvalid m_tready m_tdata    | one record write
//          |           | m_tuser m_tlast              | wide_write, last_write
//  cfg_    | in        | cfg_wr_en cfg_wr_data        | persist_limit
//
// The front end takes one input beat per cycle while the queue is not full and updates
// records and counters at once. The write sequencer sends one record write per cycle while
// m_tready is high (up to 9 per item); the write-set queue holds QUEUE_DEPTH sets beyond the one
// being sent. Items causing no write, including presets, never enter the queue.
// Synchronous active-low reset clears records, counters and the queue; limit returns to 10.
// A stalled m_ side only backs up the queue; s_tready drops when the queue is full.
module qualified_extreme_history_tracker #(
    parameter int QUEUE_DEPTH = qeht_pkg::QUEUE_DEPTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [qeht_pkg::LIMIT_W-1:0]       cfg_wr_data,   // persist_limit
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // load_channel, load_value, cell_min_mv, cell_max_mv, pack_temp_low, pack_temp_high,
    // pack_current, full_capacity, board_temp_high, error_flags, zero pad
    input  logic [qeht_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tuser,       // func
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [qeht_pkg::M_TDATA_W-1:0]     m_tdata,       // channel, value, zero pad
    output logic                               m_tuser,       // wide_write
    output logic                               m_tlast        // last_write
);
    import qeht_pkg::*;

    write_set_t push_set;
    write_set_t q_head;
    logic       push;
    logic       pop;
    logic       q_empty;
    logic       q_full;

    qeht_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .push        (push),
        .push_set    (push_set),
        .q_full      (q_full)
    );

    qeht_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_set (push_set),
        .pop      (pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    qeht_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_head   (q_head),
        .q_empty  (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* src/qeht_front.sv */
// Front end: accepts beats, qualifies samples, updates records and counters, queues writes.
module qeht_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [qeht_pkg::LIMIT_W-1:0]       cfg_wr_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [qeht_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tuser,
    output logic                               push,
    output qeht_pkg::write_set_t               push_set,
    input  logic                               q_full
);
    import qeht_pkg::*;

    in_beat_t                      beat;
    logic [NCHAN-1:0][REC_W-1:0]   rec_reg, rec_next;
    logic [NCHAN-1:0][CNT_W-1:0]   cnt_reg, cnt_next;
    logic [LIMIT_W-1:0]            limit_reg, limit_next;
    logic [NCHAN-1:0][REC_W-1:0]   samp;
    logic [NCHAN-1:0]              qual;
    logic [NCHAN-1:0][CNT_W-1:0]   cnt_inc;
    logic [NCHAN-1:0]              wr;
    logic                          accept;
    logic                          is_sample;
    logic                          is_load;

    assign beat      = in_beat_t'(s_tdata);
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign is_sample = accept && (s_tuser == FUNC_SAMPLE);
    assign is_load   = accept && (s_tuser == FUNC_LOAD);

    always_comb begin
        samp[CH_CELL_MIN]  = beat.cell_min_mv;
        samp[CH_CELL_MAX]  = beat.cell_max_mv;
        samp[CH_TEMP_MIN]  = {8'h00, beat.pack_temp_low};
        samp[CH_TEMP_MAX]  = {8'h00, beat.pack_temp_high};
        samp[CH_DCHG_PEAK] = beat.pack_current;
        samp[CH_CHG_PEAK]  = beat.pack_current;
        samp[CH_CAPACITY]  = beat.full_capacity;
        samp[CH_BOARD_TMP] = beat.board_temp_high;
        samp[CH_FLAGS]     = beat.error_flags;
    end

    always_comb begin
        qual[CH_CELL_MIN]  = samp[CH_CELL_MIN] < rec_reg[CH_CELL_MIN];
        qual[CH_CELL_MAX]  = samp[CH_CELL_MAX] > rec_reg[CH_CELL_MAX];
        qual[CH_TEMP_MIN]  = samp[CH_TEMP_MIN] < rec_reg[CH_TEMP_MIN];
        qual[CH_TEMP_MAX]  = samp[CH_TEMP_MAX] > rec_reg[CH_TEMP_MAX];
        qual[CH_DCHG_PEAK] = ($signed(samp[CH_DCHG_PEAK]) < $signed(rec_reg[CH_DCHG_PEAK]))
                             && samp[CH_DCHG_PEAK][REC_W-1];
        qual[CH_CHG_PEAK]  = ($signed(samp[CH_CHG_PEAK]) > $signed(rec_reg[CH_CHG_PEAK]))
                             && !samp[CH_CHG_PEAK][REC_W-1] && (samp[CH_CHG_PEAK] != '0);
        qual[CH_CAPACITY]  = samp[CH_CAPACITY] > rec_reg[CH_CAPACITY];
        qual[CH_BOARD_TMP] = samp[CH_BOARD_TMP] > rec_reg[CH_BOARD_TMP];
        qual[CH_FLAGS]     = samp[CH_FLAGS] != rec_reg[CH_FLAGS];
    end

    always_comb begin
        for (int i = 0; i < NCHAN; i++) begin
            cnt_inc[i] = (cnt_reg[i] == CNT_MAX) ? CNT_MAX : cnt_reg[i] + 1'b1;
            wr[i]      = qual[i] && (cnt_inc[i] > limit_reg);
        end
    end

    always_comb begin
        rec_next   = rec_reg;
        cnt_next   = cnt_reg;
        limit_next = cfg_wr_en ? cfg_wr_data : limit_reg;
        if (is_sample) begin
            for (int i = 0; i < NCHAN; i++) begin
                if (!qual[i] || wr[i]) begin
                    cnt_next[i] = '0;
                end else begin
                    cnt_next[i] = cnt_inc[i];
                end
                if (wr[i]) begin
                    rec_next[i] = samp[i];
                end
            end
        end
        if (is_load) begin
            for (int i = 0; i < NCHAN; i++) begin
                if (beat.load_channel == CH_W'(i)) begin
                    if (beat.load_channel == CH_TEMP_MIN || beat.load_channel == CH_TEMP_MAX) begin
                        rec_next[i] = {8'h00, beat.load_value[7:0]};
                    end else begin
                        rec_next[i] = beat.load_value;
                    end
                end
            end
        end
    end

    assign push           = is_sample && (|wr);
    assign push_set.mask  = wr;
    assign push_set.value = samp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg   <= '0;
            cnt_reg   <= '0;
            limit_reg <= LIMIT_RESET;
        end else begin
            rec_reg   <= rec_next;
            cnt_reg   <= cnt_next;
            limit_reg <= limit_next;
        end
    end

`ifndef ASSERT_OFF
    a_load_keeps_counters: assert property (@(posedge aclk) disable iff (!aresetn)
        is_load |=> $stable(cnt_reg))
        else $error("counters changed on a load beat");
    a_flag_write_updates: assert property (@(posedge aclk) disable iff (!aresetn)
        (is_sample && wr[CH_FLAGS]) |=> (rec_reg[CH_FLAGS] == $past(beat.error_flags)))
        else $error("flag record not updated after write");
`endif

endmodule

/* src/qeht_queue.sv */
// Write-set queue: short FIFO between front end and write sequencer.
module qeht_queue #(
    parameter int DEPTH = qeht_pkg::QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  qeht_pkg::write_set_t  push_set,
    input  logic                  pop,
    output qeht_pkg::write_set_t  head,
    output logic                  empty,
    output logic                  full
);
    import qeht_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_Q = $clog2(DEPTH + 1);

    write_set_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_Q-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_Q'(DEPTH));
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_set;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_Q'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

/* src/qeht_back.sv */
// Write sequencer: drains queued write sets one channel per beat in channel order.
module qeht_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  qeht_pkg::write_set_t              q_head,
    input  logic                              q_empty,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [qeht_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import qeht_pkg::*;

    logic [NCHAN-1:0]              work_mask_reg, work_mask_next;
    logic [NCHAN-1:0][REC_W-1:0]   work_value_reg, work_value_next;
    logic                          out_valid_reg, out_valid_next;
    out_beat_t                     out_beat_reg, out_beat_next;
    logic                          out_wide_reg, out_wide_next;
    logic                          out_last_reg, out_last_next;
    logic [CH_W-1:0]               sel;
    logic [NCHAN-1:0]              rest;
    logic                          load_out;
    logic                          have_work;
    logic                          emit;

    assign load_out  = !out_valid_reg || m_tready;
    assign have_work = |work_mask_reg;
    assign emit      = load_out && have_work;

    always_comb begin
        sel = '0;
        for (int i = NCHAN - 1; i >= 0; i--) begin
            if (work_mask_reg[i]) begin
                sel = CH_W'(i);
            end
        end
        rest      = work_mask_reg;
        rest[sel] = 1'b0;
    end

    assign pop = !q_empty && (!have_work || (emit && (rest == '0)));

    always_comb begin
        work_mask_next  = work_mask_reg;
        work_value_next = work_value_reg;
        out_valid_next  = out_valid_reg;
        out_beat_next   = out_beat_reg;
        out_wide_next   = out_wide_reg;
        out_last_next   = out_last_reg;
        if (pop) begin
            work_mask_next  = q_head.mask;
            work_value_next = q_head.value;
        end else if (emit) begin
            work_mask_next  = rest;
        end
        if (emit) begin
            out_valid_next        = 1'b1;
            out_beat_next.pad     = '0;
            out_beat_next.channel = sel;
            out_beat_next.value   = work_value_reg[sel];
            out_wide_next         = !(sel == CH_TEMP_MIN || sel == CH_TEMP_MAX);
            out_last_next         = (rest == '0);
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_mask_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            work_mask_reg <= work_mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_value_reg <= work_value_next;
        out_beat_reg   <= out_beat_next;
        out_wide_reg   <= out_wide_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_beat_reg;
    assign m_tuser  = out_wide_reg;
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_empty)
        else $error("pop from empty queue");
    a_more_after_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && (rest != '0)) |=> have_work)
        else $error("write set dropped before its last beat");
`endif

endmodule
